// ----- rtl/core/u3cjk_pkg.sv -----
`default_nettype none

package u3cjk_pkg;

  // position inside a three-byte sequence
  localparam logic [1:0] PosLead   = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosThird  = 2'd2;

  // lead byte of a three-byte sequence has the form 1110xxxx
  localparam logic [3:0] LeadPrefix = 4'hE;

  // bounds of the cjk unified ideograph range
  localparam logic [15:0] CjkLow  = 16'h4E00;
  localparam logic [15:0] CjkHigh = 16'h9FA5;

  // decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0] pos;
    logic [9:0] partial;
    logic       err;
  } state_t;

  // one result transaction
  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_code;
    logic        is_cjk;
    logic        string_done;
    logic        decode_error;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/u3cjk_step.sv -----
`default_nettype none

module u3cjk_step (
  input  var u3cjk_pkg::state_t  state_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              end_of_string_i,
  output u3cjk_pkg::state_t      state_o,
  output u3cjk_pkg::result_t     result_o,
  output logic                   has_result_o
);

  u3cjk_pkg::state_t adv;
  logic [15:0]       unit;
  logic              have;

  // sequence assembly, ignored once the string has an error
  always_comb begin
    adv  = state_i;
    unit = '0;
    have = 1'b0;
    if (!state_i.err) begin
      unique case (state_i.pos)
        u3cjk_pkg::PosSecond: begin
          adv.partial = {state_i.partial[3:0], data_byte_i[5:0]};
          adv.pos     = u3cjk_pkg::PosThird;
        end
        u3cjk_pkg::PosThird: begin
          unit        = {state_i.partial, data_byte_i[5:0]};
          have        = 1'b1;
          adv.partial = '0;
          adv.pos     = u3cjk_pkg::PosLead;
        end
        default: begin
          // lead position; the unused code behaves the same
          if (data_byte_i[7:4] == u3cjk_pkg::LeadPrefix) begin
            adv.partial = {6'd0, data_byte_i[3:0]};
            adv.pos     = u3cjk_pkg::PosSecond;
          end else begin
            adv.err = 1'b1;
            adv.pos = u3cjk_pkg::PosLead;
          end
        end
      endcase
      // truncated sequence at end of string
      if (end_of_string_i && adv.pos != u3cjk_pkg::PosLead) begin
        adv.err = 1'b1;
      end
    end
  end

  // result and state for the next byte
  always_comb begin
    result_o.code_unit    = unit;
    result_o.has_code     = have;
    result_o.is_cjk       = have && (unit >= u3cjk_pkg::CjkLow) && (unit <= u3cjk_pkg::CjkHigh);
    result_o.string_done  = end_of_string_i;
    result_o.decode_error = end_of_string_i && adv.err;
    has_result_o          = have || end_of_string_i;
    state_o               = end_of_string_i ? '0 : adv;
  end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_three_byte_cjk_decoder_core.sv -----
`default_nettype none

// Decodes a stream of UTF-8 bytes, one byte per transaction, holding only
// three-byte sequences (lead 1110xxxx), into 16-bit code units, each flagged
// when it falls in 0x4E00..0x9FA5. A unit comes out on the third byte of its
// sequence; the byte marked end_of_string always yields a closing result with
// string_done set, and decode_error on it tells the consumer to drop the whole
// string (bad lead byte or truncated sequence). Other bytes yield no result.
// Continuation prefixes are not checked. Each byte goes through shallow logic
// from the decoder state register into a result register, so one byte is
// accepted every cycle unless in_stall_o is high; a two-entry output stage
// (result register plus skid register) lets input keep flowing while the
// output stalls, until a second result is waiting behind the one held at the
// output. A result is registered into the result register, or into the skid register if that is held.
module utf8_three_byte_cjk_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_string_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      code_unit_o,
  output logic             has_code_o,
  output logic             is_cjk_o,
  output logic             string_done_o,
  output logic             decode_error_o
);

  u3cjk_pkg::state_t  state_q, state_d;
  u3cjk_pkg::result_t step_res;
  u3cjk_pkg::result_t out_q, skid_q;
  logic               step_has;
  logic               out_valid_q, skid_valid_q;
  logic               in_fire, out_fire, res_valid;

  // per-byte decode
  u3cjk_step u_step (
    .state_i        (state_q),
    .data_byte_i    (data_byte_i),
    .end_of_string_i(end_of_string_i),
    .state_o        (state_d),
    .result_o       (step_res),
    .has_result_o   (step_has)
  );

  // handshake
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign res_valid  = in_fire && step_has;

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // output control: result register with skid behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= step_res;
      end else begin
        out_q <= step_res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_unit_o    = out_q.code_unit;
  assign has_code_o     = out_q.has_code;
  assign is_cjk_o       = out_q.is_cjk;
  assign string_done_o  = out_q.string_done;
  assign decode_error_o = out_q.decode_error;

  // skid entry is only used behind a full result register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a transaction while the result register is empty");

  // the unused position code is never reached
  a_pos_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos != 2'd3)
    else $error("byte position reached the unused code");

  // an error is only reported on the closing result and never with a code unit
  a_error_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> string_done_o && !has_code_o)
    else $error("decode error outside a clean closing result");

  // the range flag only accompanies a code unit
  a_cjk_needs_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_cjk_o |-> has_code_o)
    else $error("cjk flag set without a code unit");

  // a closing byte leaves the decoder in its reset state
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_string_i |=> state_q == '0)
    else $error("decoder state not cleared after end of string");

endmodule

`default_nettype wire
